/* rtl/bpcc_pkg.sv */
// Shared constants and types for the binary plus-cross counter.
`default_nettype none

package bpcc_pkg;

   // Default sizing of the column store.
   localparam int DEF_MAX_WIDTH = 2048;
   localparam int DEF_MAX_ARM   = 64;

   // Field and register widths.
   localparam int COUNT_W     = 23;
   localparam int ARM_CFG_W   = 7;
   localparam int WIDTH_CFG_W = 12;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 12;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_ARM_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_WIDTH  = 1'b1;

   // Register values after reset.
   localparam logic [ARM_CFG_W-1:0]   ARM_RESET   = 7'd1;
   localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET = 12'd2048;

   // Saturation value of the cross count.
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Column store sweep controller.
   typedef enum logic {
      CLR_SWEEP,
      CLR_IDLE
   } clr_state_type;

   // Pipeline control shared by the scan, store and tally units.
   typedef struct packed {
      logic accept;     // input transfer at this edge
      logic retire;     // stage-one item completes at this edge
      logic frame_end;  // the accepted item closes the frame
      logic s1_valid;   // stage one holds an item
   } pipe_ctrl_type;

endpackage

`default_nettype wire

/* rtl/bpcc_scan.sv */
// Raster position tracking, row runs and the stage-one item register.
`default_nettype none

module bpcc_scan #(
   parameter int MAX_WIDTH = bpcc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_ARM   = bpcc_pkg::DEF_MAX_ARM,
   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int WE_W  = $clog2(MAX_WIDTH + 1),
   localparam int PH_W  = (MAX_ARM > 1) ? $clog2(MAX_ARM) : 1,
   localparam int K_W   = $clog2(MAX_ARM + 1),
   localparam int RUN_W = $clog2(2 * MAX_ARM + 2)
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire bpcc_pkg::pipe_ctrl_type ctrl,
   input  wire                          pixel,
   input  wire                          frame_end,
   input  wire  [WE_W-1:0]              w_eff,
   input  wire  [K_W-1:0]               k_eff,
   input  wire  [RUN_W-1:0]             full,
   output logic [COL_W-1:0]             rd_addr,
   output logic                         s1_valid,
   output logic                         s1_pixel,
   output logic                         s1_frame_end,
   output logic [COL_W-1:0]             s1_col,
   output logic [PH_W-1:0]              s1_rd_bit,
   output logic                         s1_fw_en,
   output logic [COL_W-1:0]             s1_fw_addr,
   output logic [PH_W-1:0]              s1_fw_bit,
   output logic                         s1_fw_val,
   output logic                         fwd_run_sel,
   output logic                         fwd_flag_sel,
   output logic                         fwd_flag_val
);

   localparam int XW   = (COL_W + 1 > WE_W) ? COL_W + 1 : WE_W;
   localparam int CK_W = (COL_W > K_W) ? COL_W : K_W;
   localparam int PK_W = ((PH_W > K_W) ? PH_W : K_W) + 1;
   localparam logic [PH_W-1:0] PH_LAST = PH_W'(MAX_ARM - 1);
   localparam logic [PK_W-1:0] RING    = PK_W'(MAX_ARM);

   // Positional state.
   logic [COL_W-1:0] col_pos_ff, col_pos_in;
   logic [PH_W-1:0]  phase_ff, phase_in;
   logic [RUN_W-1:0] row_run_ff, row_run_in;

   // Stage-one item register.
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_pixel_ff, s1_fe_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [PH_W-1:0]  s1_rd_bit_ff;
   logic             s1_fw_en_ff;
   logic [COL_W-1:0] s1_fw_addr_ff;
   logic [PH_W-1:0]  s1_fw_bit_ff;
   logic             s1_fw_val_ff;
   logic             fwd_run_ff, fwd_flag_ff, fwd_val_ff;

   // Stage-zero combinational values.
   logic [XW-1:0]    col_ext, w_ext, next_ext;
   logic             wrap_start, wrap_end;
   logic [COL_W-1:0] c0, col_next;
   logic [PH_W-1:0]  ph0, rd0;
   logic [PK_W-1:0]  ph_ext, kp_ext, rd_wide;
   logic [RUN_W-1:0] rr_base, rr_new;
   logic             hflag0, fw_en0;
   logic [COL_W-1:0] fw_addr0;
   logic             fwd_run0, fwd_flag0;

   function automatic logic [PH_W-1:0] phase_step(input logic [PH_W-1:0] ph);
      logic [PH_W-1:0] res;
      if (ph == PH_LAST) begin
         res = '0;
      end else begin
         res = ph + PH_W'(1);
      end
      return res;
   endfunction

   // Column, ring phase and row run for the arriving pixel.
   always_comb begin
      col_ext    = XW'(col_pos_ff);
      w_ext      = XW'(w_eff);
      wrap_start = col_ext >= w_ext;
      c0         = wrap_start ? '0 : col_pos_ff;
      ph0        = wrap_start ? phase_step(phase_ff) : phase_ff;
      rr_base    = wrap_start ? '0 : row_run_ff;

      if (pixel) begin
         rr_new = (rr_base < full) ? rr_base + RUN_W'(1) : rr_base;
      end else begin
         rr_new = '0;
      end
      hflag0 = rr_new >= full;

      // The arm flag lands K columns behind the current pixel.
      fw_en0   = (k_eff != '0) && (CK_W'(c0) >= CK_W'(k_eff));
      fw_addr0 = COL_W'(CK_W'(c0) - CK_W'(k_eff));

      // Ring slot written K rows ago.
      ph_ext  = PK_W'(ph0);
      kp_ext  = PK_W'(k_eff);
      rd_wide = (ph_ext >= kp_ext) ? ph_ext - kp_ext : ph_ext + RING - kp_ext;
      rd0     = PH_W'(rd_wide);

      next_ext = XW'(c0) + XW'(1);
      wrap_end = next_ext >= w_ext;
      col_next = wrap_end ? '0 : COL_W'(next_ext);

      // The item leaving stage one writes at the same edge as this read.
      fwd_run0  = s1_valid_ff && (s1_col_ff == c0);
      fwd_flag0 = s1_valid_ff && s1_fw_en_ff && (s1_fw_addr_ff == c0) &&
                  (s1_fw_bit_ff == rd0);
   end

   // Next positional state.
   always_comb begin
      col_pos_in = col_pos_ff;
      phase_in   = phase_ff;
      row_run_in = row_run_ff;
      if (ctrl.accept) begin
         if (frame_end) begin
            col_pos_in = '0;
            phase_in   = '0;
            row_run_in = '0;
         end else begin
            col_pos_in = col_next;
            phase_in   = wrap_end ? phase_step(ph0) : ph0;
            row_run_in = wrap_end ? '0 : rr_new;
         end
      end
   end

   always_comb begin
      if (ctrl.accept) begin
         s1_valid_in = 1'b1;
      end else if (ctrl.retire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff  <= '0;
         phase_ff    <= '0;
         row_run_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_pos_ff  <= col_pos_in;
         phase_ff    <= phase_in;
         row_run_ff  <= row_run_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Stage-one payload, loaded on each input transfer.
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         s1_pixel_ff   <= pixel;
         s1_fe_ff      <= frame_end;
         s1_col_ff     <= c0;
         s1_rd_bit_ff  <= rd0;
         s1_fw_en_ff   <= fw_en0;
         s1_fw_addr_ff <= fw_addr0;
         s1_fw_bit_ff  <= ph0;
         s1_fw_val_ff  <= hflag0;
         fwd_run_ff    <= fwd_run0;
         fwd_flag_ff   <= fwd_flag0;
         fwd_val_ff    <= s1_fw_val_ff;
      end
   end

   assign rd_addr      = c0;
   assign s1_valid     = s1_valid_ff;
   assign s1_pixel     = s1_pixel_ff;
   assign s1_frame_end = s1_fe_ff;
   assign s1_col       = s1_col_ff;
   assign s1_rd_bit    = s1_rd_bit_ff;
   assign s1_fw_en     = s1_fw_en_ff;
   assign s1_fw_addr   = s1_fw_addr_ff;
   assign s1_fw_bit    = s1_fw_bit_ff;
   assign s1_fw_val    = s1_fw_val_ff;
   assign fwd_run_sel  = fwd_run_ff;
   assign fwd_flag_sel = fwd_flag_ff;
   assign fwd_flag_val = fwd_val_ff;

endmodule

`default_nettype wire

/* rtl/bpcc_colmem.sv */
// Per-column store of vertical runs and arm flags, with its clearing sweep.
`default_nettype none

module bpcc_colmem #(
   parameter int MAX_WIDTH = bpcc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_ARM   = bpcc_pkg::DEF_MAX_ARM,
   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int PH_W  = (MAX_ARM > 1) ? $clog2(MAX_ARM) : 1,
   localparam int RUN_W = $clog2(2 * MAX_ARM + 2)
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire bpcc_pkg::pipe_ctrl_type ctrl,
   input  wire  [COL_W-1:0]             rd_addr,
   input  wire  [COL_W-1:0]             run_addr,
   input  wire  [RUN_W-1:0]             run_val,
   input  wire                          fw_en,
   input  wire  [COL_W-1:0]             fw_addr,
   input  wire  [PH_W-1:0]              fw_bit,
   input  wire                          fw_val,
   output logic [RUN_W-1:0]             run_q,
   output logic [MAX_ARM-1:0]           flag_q,
   output logic                         busy
);

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_WIDTH - 1);

   logic [RUN_W-1:0]   run_mem  [MAX_WIDTH];
   logic [MAX_ARM-1:0] flag_mem [MAX_WIDTH];

   bpcc_pkg::clr_state_type state_ff, state_in;
   logic [COL_W-1:0]        clr_addr_ff, clr_addr_in;
   logic                    clr_we;
   logic [RUN_W-1:0]        run_q_ff;
   logic [MAX_ARM-1:0]      flag_q_ff;

   // Sweep sequencing: start on a frame-end transfer, hold while stage one is busy.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bpcc_pkg::CLR_SWEEP: begin
            if (!ctrl.s1_valid && (clr_addr_ff == LAST_COL)) begin
               state_in = bpcc_pkg::CLR_IDLE;
            end
         end
         bpcc_pkg::CLR_IDLE: begin
            if (ctrl.accept && ctrl.frame_end) begin
               state_in = bpcc_pkg::CLR_SWEEP;
            end
         end
         default: begin
            state_in = bpcc_pkg::CLR_SWEEP;
         end
      endcase
   end

   // Sweep outputs and address counter.
   always_comb begin
      busy   = 1'b0;
      clr_we = 1'b0;
      case (state_ff)
         bpcc_pkg::CLR_SWEEP: begin
            busy   = 1'b1;
            clr_we = !ctrl.s1_valid;
         end
         bpcc_pkg::CLR_IDLE: begin
            busy   = 1'b0;
            clr_we = 1'b0;
         end
         default: begin
            busy   = 1'b1;
            clr_we = 1'b0;
         end
      endcase
      if (!busy) begin
         clr_addr_in = '0;
      end else if (clr_we) begin
         clr_addr_in = clr_addr_ff + COL_W'(1);
      end else begin
         clr_addr_in = clr_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bpcc_pkg::CLR_SWEEP;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Storage: one write per cycle, registered read for the incoming pixel.
   always_ff @(posedge clock) begin
      if (clr_we) begin
         run_mem[clr_addr_ff]  <= '0;
         flag_mem[clr_addr_ff] <= '0;
      end else if (ctrl.retire) begin
         run_mem[run_addr] <= run_val;
         if (fw_en) begin
            flag_mem[fw_addr][fw_bit] <= fw_val;
         end
      end
      if (ctrl.accept) begin
         run_q_ff  <= run_mem[rd_addr];
         flag_q_ff <= flag_mem[rd_addr];
      end
   end

   assign run_q  = run_q_ff;
   assign flag_q = flag_q_ff;

   // The sweep never competes with an item write.
   a_sweep_exclusive : assert property (@(posedge clock) disable iff (reset)
      ctrl.retire |-> !clr_we)
      else $error("clearing sweep wrote while an item retired");

endmodule

`default_nettype wire

/* rtl/bpcc_tally.sv */
// Cross detection for the stage-one item, running total and result register.
`default_nettype none

module bpcc_tally #(
   parameter int MAX_ARM = bpcc_pkg::DEF_MAX_ARM,
   localparam int PH_W  = (MAX_ARM > 1) ? $clog2(MAX_ARM) : 1,
   localparam int RUN_W = $clog2(2 * MAX_ARM + 2)
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire bpcc_pkg::pipe_ctrl_type      ctrl,
   input  wire                               s1_pixel,
   input  wire                               s1_frame_end,
   input  wire  [PH_W-1:0]                   s1_rd_bit,
   input  wire                               fwd_run_sel,
   input  wire                               fwd_flag_sel,
   input  wire                               fwd_flag_val,
   input  wire  [RUN_W-1:0]                  run_q,
   input  wire  [MAX_ARM-1:0]                flag_q,
   input  wire                               k_zero,
   input  wire  [RUN_W-1:0]                  full,
   input  wire                               rsp_stall,
   output logic [RUN_W-1:0]                  run_new,
   output logic                              out_free,
   output logic                              rsp_valid,
   output logic [bpcc_pkg::COUNT_W-1:0]      rsp_cross_count
);

   logic [RUN_W-1:0]              prev_run_ff, run_old;
   logic                          flag_bit, hit;
   logic [bpcc_pkg::COUNT_W-1:0]  total_ff, total_in, total_inc;
   logic [bpcc_pkg::COUNT_W-1:0]  count_ff;
   logic                          rsp_valid_ff, rsp_valid_in;

   // Vertical run update and the cross test.
   always_comb begin
      run_old = fwd_run_sel ? prev_run_ff : run_q;
      if (s1_pixel) begin
         run_new = (run_old < full) ? run_old + RUN_W'(1) : run_old;
      end else begin
         run_new = '0;
      end
      flag_bit = fwd_flag_sel ? fwd_flag_val : flag_q[s1_rd_bit];
      hit      = k_zero ? s1_pixel : ((run_new >= full) && flag_bit);

      if (hit && (total_ff != bpcc_pkg::COUNT_MAX)) begin
         total_inc = total_ff + bpcc_pkg::COUNT_W'(1);
      end else begin
         total_inc = total_ff;
      end
   end

   // Total and result register updates.
   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      total_in = total_ff;
      if (ctrl.retire) begin
         total_in = s1_frame_end ? '0 : total_inc;
      end
      if (ctrl.retire && s1_frame_end) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Last run written, for a read of the same column at the same edge.
   always_ff @(posedge clock) begin
      if (ctrl.retire) begin
         prev_run_ff <= run_new;
      end
      if (ctrl.retire && s1_frame_end) begin
         count_ff <= total_inc;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cross_count = count_ff;

endmodule

`default_nettype wire

/* rtl/binary_plus_cross_counter.sv */
// Top level of the binary plus-cross counter: configuration, control and wiring.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_stall  req_pixel, req_frame_end
//   rsp_     out        rsp_valid / rsp_stall  rsp_cross_count
//   csr_     in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One pixel is taken per cycle while the input is not stalled; in stage one
// the column store read of the previous edge meets the run and flag update.
// After a frame-end transfer the input stalls while the column store is swept,
// one column per cycle once stage one is empty; the same sweep follows reset.
// The count is registered when the frame-end pixel retires from stage one.
// A stalled result holds back only a frame-end pixel.
`default_nettype none

module binary_plus_cross_counter #(
   parameter int MAX_WIDTH = bpcc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_ARM   = bpcc_pkg::DEF_MAX_ARM
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire                                 req_pixel,
   input  wire                                 req_frame_end,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [bpcc_pkg::COUNT_W-1:0]        rsp_cross_count,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [bpcc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [bpcc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WE_W   = $clog2(MAX_WIDTH + 1);
   localparam int PH_W   = (MAX_ARM > 1) ? $clog2(MAX_ARM) : 1;
   localparam int K_W    = $clog2(MAX_ARM + 1);
   localparam int RUN_W  = $clog2(2 * MAX_ARM + 2);
   localparam int CMP_W  = (WE_W > bpcc_pkg::WIDTH_CFG_W) ? WE_W : bpcc_pkg::WIDTH_CFG_W;
   localparam int KC_W   = (K_W > bpcc_pkg::ARM_CFG_W) ? K_W : bpcc_pkg::ARM_CFG_W;

   // Configuration registers.
   logic [bpcc_pkg::ARM_CFG_W-1:0]   arm_length_ff, arm_length_in;
   logic [bpcc_pkg::WIDTH_CFG_W-1:0] row_width_ff, row_width_in;

   // Settings in force.
   logic [CMP_W-1:0] width_ext;
   logic [KC_W-1:0]  arm_ext;
   logic [WE_W-1:0]  w_eff;
   logic [K_W-1:0]   k_eff;
   logic [RUN_W-1:0] full;
   logic             k_zero;

   bpcc_pkg::pipe_ctrl_type ctrl;
   logic             busy, out_free;

   logic [COL_W-1:0] rd_addr, s1_col, s1_fw_addr;
   logic             s1_valid, s1_pixel, s1_frame_end;
   logic [PH_W-1:0]  s1_rd_bit, s1_fw_bit;
   logic             s1_fw_en, s1_fw_val;
   logic             fwd_run_sel, fwd_flag_sel, fwd_flag_val;
   logic [RUN_W-1:0] run_q, run_new;
   logic [MAX_ARM-1:0] flag_q;

   // Register writes.
   always_comb begin
      csr_ready     = 1'b1;
      arm_length_in = arm_length_ff;
      row_width_in  = row_width_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bpcc_pkg::REG_ARM_LENGTH: begin
               arm_length_in = csr_wdata[bpcc_pkg::ARM_CFG_W-1:0];
            end
            bpcc_pkg::REG_ROW_WIDTH: begin
               row_width_in = csr_wdata[bpcc_pkg::WIDTH_CFG_W-1:0];
            end
            default: begin
               arm_length_in = arm_length_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_length_ff <= bpcc_pkg::ARM_RESET;
         row_width_ff  <= bpcc_pkg::WIDTH_RESET;
      end else begin
         arm_length_ff <= arm_length_in;
         row_width_ff  <= row_width_in;
      end
   end

   // Clamp the settings to the store's dimensions.
   always_comb begin
      width_ext = CMP_W'(row_width_ff);
      if (width_ext == '0) begin
         w_eff = WE_W'(1);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         w_eff = WE_W'(MAX_WIDTH);
      end else begin
         w_eff = WE_W'(width_ext);
      end
      arm_ext = KC_W'(arm_length_ff);
      k_eff   = (arm_ext > KC_W'(MAX_ARM)) ? K_W'(MAX_ARM) : K_W'(arm_ext);
      k_zero  = k_eff == '0;
      full    = RUN_W'({k_eff, 1'b1});
   end

   // Pipeline control.
   always_comb begin
      ctrl.accept    = req_valid && !busy;
      ctrl.retire    = s1_valid && (!s1_frame_end || out_free);
      ctrl.frame_end = req_frame_end;
      ctrl.s1_valid  = s1_valid;
      req_stall      = busy;
   end

   bpcc_scan #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_ARM   (MAX_ARM)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .pixel        (req_pixel),
      .frame_end    (req_frame_end),
      .w_eff        (w_eff),
      .k_eff        (k_eff),
      .full         (full),
      .rd_addr      (rd_addr),
      .s1_valid     (s1_valid),
      .s1_pixel     (s1_pixel),
      .s1_frame_end (s1_frame_end),
      .s1_col       (s1_col),
      .s1_rd_bit    (s1_rd_bit),
      .s1_fw_en     (s1_fw_en),
      .s1_fw_addr   (s1_fw_addr),
      .s1_fw_bit    (s1_fw_bit),
      .s1_fw_val    (s1_fw_val),
      .fwd_run_sel  (fwd_run_sel),
      .fwd_flag_sel (fwd_flag_sel),
      .fwd_flag_val (fwd_flag_val)
   );

   bpcc_colmem #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_ARM   (MAX_ARM)
   ) u_colmem (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .rd_addr  (rd_addr),
      .run_addr (s1_col),
      .run_val  (run_new),
      .fw_en    (s1_fw_en),
      .fw_addr  (s1_fw_addr),
      .fw_bit   (s1_fw_bit),
      .fw_val   (s1_fw_val),
      .run_q    (run_q),
      .flag_q   (flag_q),
      .busy     (busy)
   );

   bpcc_tally #(
      .MAX_ARM (MAX_ARM)
   ) u_tally (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .s1_pixel        (s1_pixel),
      .s1_frame_end    (s1_frame_end),
      .s1_rd_bit       (s1_rd_bit),
      .fwd_run_sel     (fwd_run_sel),
      .fwd_flag_sel    (fwd_flag_sel),
      .fwd_flag_val    (fwd_flag_val),
      .run_q           (run_q),
      .flag_q          (flag_q),
      .k_zero          (k_zero),
      .full            (full),
      .rsp_stall       (rsp_stall),
      .run_new         (run_new),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_cross_count (rsp_cross_count)
   );

   // A frame-end transfer is followed by the clearing stall.
   a_frame_end_stalls : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_frame_end |=> req_stall)
      else $error("input not stalled after a frame-end transfer");

   // A result only ever follows the retirement of a frame-end pixel.
   a_result_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctrl.retire && s1_frame_end))
      else $error("result raised without a retiring frame-end pixel");

   // No new pixel enters while a frame-end pixel waits in stage one.
   a_no_entry_behind_frame_end : assert property (@(posedge clock) disable iff (reset)
      s1_valid && s1_frame_end |-> !ctrl.accept)
      else $error("pixel accepted behind a pending frame end");

endmodule

`default_nettype wire
